[hdl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/gwma_pkg.sv]
// Package: types and constants of the growing-window moving average.
package gwma_pkg;

    localparam int DEFAULT_WINDOW = 16;
    localparam int SAMPLE_W       = 16;
    localparam int MODE_W         = 2;

    localparam logic [MODE_W-1:0] MODE_NORMAL     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FORCED     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INVALIDATE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ABS,
        S_DIV,
        S_FIN
    } t_state;

endpackage

[hdl/growing_window_moving_average.sv]
// Growing-window moving average: each sample word (normal or forced update) goes
// through a ring read and a sum update, then a restoring divider that retires one
// quotient bit per cycle over SUM_W = 16 + clog2(WINDOW+1) bits, then a sign fixup.
// Rejected, invalidate and unused mode words complete in the accept cycle. One word
// is in work at a time; the result sits in an output register, and a new word is
// taken only while that register is empty or being read, so a stalled output holds
// off the input.
`include "assert_macros.svh"

module growing_window_moving_average #(
    parameter int WINDOW = gwma_pkg::DEFAULT_WINDOW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [gwma_pkg::MODE_W-1:0]   i_mode,
    input  logic signed [gwma_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [gwma_pkg::SAMPLE_W-1:0] o_average,
    output logic                          o_valid_res,
    output logic                          o_status,
    output logic                          o_became_valid,
    output logic                          o_changed,
    output logic                          o_invalidated_event
);

    localparam int SW     = gwma_pkg::SAMPLE_W;
    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SW + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    gwma_pkg::t_state r_state, n_state;

    logic                    r_write_en, n_write_en;
    logic [PTR_W-1:0]        r_wptr, n_wptr;
    logic [CNT_W-1:0]        r_count, n_count;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic signed [SW-1:0]    r_last_avg, n_last_avg;
    logic signed [SW-1:0]    r_sample, n_sample;
    logic                    r_first, n_first;
    logic                    r_neg, n_neg;
    logic [CNT_W-1:0]        r_rem, n_rem;
    logic [SUM_W-1:0]        r_quot, n_quot;
    logic [STEP_W-1:0]       r_step, n_step;

    logic                    r_o_valid, n_o_valid;
    logic signed [SW-1:0]    r_o_average, n_o_average;
    logic                    r_o_valid_res, n_o_valid_res;
    logic                    r_o_status, n_o_status;
    logic                    r_o_became, n_o_became;
    logic                    r_o_changed, n_o_changed;
    logic                    r_o_inval, n_o_inval;

    logic                    w_slot_free;
    logic                    w_accept;
    logic                    w_inval_accept;
    logic                    w_full;
    logic                    w_take;
    logic                    w_ram_we;
    logic [SW-1:0]           w_rdata;
    logic [CNT_W:0]          w_shifted;
    logic [CNT_W:0]          w_trial;
    logic                    w_ge;
    logic [SW-1:0]           w_q16;
    logic signed [SW-1:0]    w_avg;

    assign w_slot_free = !r_o_valid || i_ready;
    assign o_ready     = (r_state == gwma_pkg::S_IDLE) && w_slot_free;
    assign w_accept    = i_valid && o_ready;
    assign w_inval_accept = w_accept && (i_mode == gwma_pkg::MODE_INVALIDATE);
    assign w_full      = (r_count == CNT_W'(WINDOW));
    assign w_take      = (i_mode == gwma_pkg::MODE_FORCED)
                      || ((i_mode == gwma_pkg::MODE_NORMAL) && r_write_en);
    assign w_ram_we    = (r_state == gwma_pkg::S_READ);

    gwma_ram #(
        .WIDTH (SW),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wptr),
        .i_wdata (r_sample),
        .i_raddr (r_wptr),
        .o_rdata (w_rdata)
    );

    assign w_shifted = {r_rem, r_quot[SUM_W-1]};
    assign w_ge      = (w_shifted >= {1'b0, r_count});
    assign w_trial   = w_shifted - {1'b0, r_count};
    assign w_q16     = r_quot[SW-1:0];
    assign w_avg     = r_neg ? $signed(-w_q16) : $signed(w_q16);

    always_comb begin
        n_state       = r_state;
        n_write_en    = r_write_en;
        n_wptr        = r_wptr;
        n_count       = r_count;
        n_sum         = r_sum;
        n_last_avg    = r_last_avg;
        n_sample      = r_sample;
        n_first       = r_first;
        n_neg         = r_neg;
        n_rem         = r_rem;
        n_quot        = r_quot;
        n_step        = r_step;
        n_o_valid     = r_o_valid && !i_ready;
        n_o_average   = r_o_average;
        n_o_valid_res = r_o_valid_res;
        n_o_status    = r_o_status;
        n_o_became    = r_o_became;
        n_o_changed   = r_o_changed;
        n_o_inval     = r_o_inval;

        if (i_cfg_we) begin
            n_write_en = i_cfg_wdata;
        end

        case (r_state)
            gwma_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_take) begin
                        n_sample = i_sample;
                        n_state  = gwma_pkg::S_READ;
                    end else begin
                        n_o_valid     = 1'b1;
                        n_o_average   = r_last_avg;
                        n_o_became    = 1'b0;
                        n_o_changed   = 1'b0;
                        n_o_valid_res = (r_count != '0);
                        n_o_status    = 1'b0;
                        n_o_inval     = 1'b0;
                        case (i_mode)
                            gwma_pkg::MODE_NORMAL: begin
                                n_o_status = 1'b1;
                            end
                            gwma_pkg::MODE_INVALIDATE: begin
                                n_o_valid_res = 1'b0;
                                n_o_inval     = (r_count != '0);
                                n_count       = '0;
                                n_wptr        = '0;
                                n_sum         = '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            gwma_pkg::S_READ: begin
                n_first = (r_count == '0);
                n_sum   = r_sum + SUM_W'(r_sample)
                        - (w_full ? SUM_W'($signed(w_rdata)) : SUM_W'(0));
                n_count = w_full ? r_count : r_count + 1'b1;
                n_wptr  = (r_wptr == PTR_W'(WINDOW - 1)) ? '0 : r_wptr + 1'b1;
                n_state = gwma_pkg::S_ABS;
            end
            gwma_pkg::S_ABS: begin
                n_neg   = r_sum[SUM_W-1];
                n_quot  = r_sum[SUM_W-1] ? -r_sum : r_sum;
                n_rem   = '0;
                n_step  = '0;
                n_state = gwma_pkg::S_DIV;
            end
            gwma_pkg::S_DIV: begin
                n_rem  = w_ge ? w_trial[CNT_W-1:0] : w_shifted[CNT_W-1:0];
                n_quot = {r_quot[SUM_W-2:0], w_ge};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = gwma_pkg::S_FIN;
                end
            end
            gwma_pkg::S_FIN: begin
                if (w_slot_free) begin
                    n_o_valid     = 1'b1;
                    n_o_average   = w_avg;
                    n_o_valid_res = 1'b1;
                    n_o_status    = 1'b0;
                    n_o_became    = r_first;
                    n_o_changed   = (w_avg != r_last_avg);
                    n_o_inval     = 1'b0;
                    n_last_avg    = w_avg;
                    n_state       = gwma_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gwma_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gwma_pkg::S_IDLE;
            r_write_en <= 1'b1;
            r_wptr     <= '0;
            r_count    <= '0;
            r_sum      <= '0;
            r_last_avg <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_write_en <= n_write_en;
            r_wptr     <= n_wptr;
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_last_avg <= n_last_avg;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample      <= n_sample;
        r_first       <= n_first;
        r_neg         <= n_neg;
        r_rem         <= n_rem;
        r_quot        <= n_quot;
        r_step        <= n_step;
        r_o_average   <= n_o_average;
        r_o_valid_res <= n_o_valid_res;
        r_o_status    <= n_o_status;
        r_o_became    <= n_o_became;
        r_o_changed   <= n_o_changed;
        r_o_inval     <= n_o_inval;
    end

    assign o_valid             = r_o_valid;
    assign o_average           = r_o_average;
    assign o_valid_res         = r_o_valid_res;
    assign o_status            = r_o_status;
    assign o_became_valid      = r_o_became;
    assign o_changed           = r_o_changed;
    assign o_invalidated_event = r_o_inval;

    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(WINDOW))
    `ASSERT_IMPL(a_became_implies_valid, i_clk, i_rst_n, o_valid && o_became_valid, o_valid_res)
    `ASSERT_NEXT(a_update_starts, i_clk, i_rst_n, w_accept && w_take, r_state == gwma_pkg::S_READ)
    `ASSERT_NEXT(a_invalidate_clears, i_clk, i_rst_n, w_inval_accept, r_count == '0 && r_wptr == '0)

endmodule

[hdl/gwma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gwma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
